// File: hw/rtl/mstc_pkg.sv
// Shared types, constants and decode functions for the tone correlator.
`default_nettype none
package mstc_pkg;

    localparam int NMODES     = 5;
    localparam int RAW_W      = 24;
    localparam int SLOT_W     = 9;
    localparam int MODE_W     = 3;
    localparam int CNT_W      = 20;
    localparam int ACC_W      = 44;
    localparam int PEAK_W     = 24;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int QDEPTH     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES = 1'd1;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd19685267;
    localparam logic [CNT_W-1:0]   MAX_FRAMES_RST = 20'd96000;

    localparam logic [MODE_W-1:0] MODE_BE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NIB = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWZ = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NBB = 3'd4;

    typedef enum logic [1:0] {
        K_ACC,
        K_READ,
        K_READZ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [RAW_W-1:0]    raw;
        logic [SLOT_W-1:0]   slot;
        logic [MODE_W-1:0]   mode;
        logic [PHASE_W-1:0]  phase;
        logic [CNT_W-1:0]    frames;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic        [ACC_W-1:0] square;
        logic signed [ACC_W-1:0] sine;
        logic signed [ACC_W-1:0] cosine;
        logic        [PEAK_W-1:0] peak;
    } t_cell;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        t_cell [NMODES-1:0]      cells;
    } t_row;

    typedef struct packed {
        logic [CNT_W-1:0]         sample_count;
        logic signed [ACC_W-1:0]  sum_value;
        logic [ACC_W-1:0]         sum_square;
        logic signed [ACC_W-1:0]  sine_corr;
        logic signed [ACC_W-1:0]  cosine_corr;
        logic [PEAK_W-1:0]        peak_abs;
        logic [CNT_W-1:0]         frames_done;
    } t_result;

    function automatic logic [RAW_W-1:0] swap_bytes(input logic [RAW_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16]};
    endfunction

    function automatic logic [RAW_W-1:0] swap_nibbles(input logic [RAW_W-1:0] w);
        return ((w & 24'hF0F0F0) >> 4) | ((w & 24'h0F0F0F) << 4);
    endfunction

    function automatic logic signed [RAW_W-1:0] decode(input logic [RAW_W-1:0] w,
                                                       input logic [MODE_W-1:0] m);
        logic [RAW_W-1:0] d;
        unique case (m)
            MODE_LE:  d = swap_bytes(w);
            MODE_NIB: d = swap_nibbles(w);
            MODE_SWZ: d = swap_nibbles(swap_bytes(w));
            MODE_NBB: d = swap_bytes(swap_nibbles(w));
            default:  d = w;
        endcase
        return signed'(d);
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mstc_in_if.sv
// Sample/read request channel.
`default_nettype none
interface mstc_in_if import mstc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [RAW_W-1:0]  raw_sample;
    logic [SLOT_W-1:0] slot;
    logic [MODE_W-1:0] read_mode;
    logic              frame_end;

    modport source (output valid, cmd, raw_sample, slot, read_mode, frame_end,
                    input ready);
    modport sink   (input valid, cmd, raw_sample, slot, read_mode, frame_end,
                    output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mstc_out_if.sv
// Accumulator readout channel.
`default_nettype none
interface mstc_out_if import mstc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CNT_W-1:0]         sample_count;
    logic signed [ACC_W-1:0]  sum_value;
    logic [ACC_W-1:0]         sum_square;
    logic signed [ACC_W-1:0]  sine_corr;
    logic signed [ACC_W-1:0]  cosine_corr;
    logic [PEAK_W-1:0]        peak_abs;
    logic [CNT_W-1:0]         frames_done;

    modport source (output valid, sample_count, sum_value, sum_square, sine_corr,
                    cosine_corr, peak_abs, frames_done, input ready);
    modport sink   (input valid, sample_count, sum_value, sum_square, sine_corr,
                    cosine_corr, peak_abs, frames_done, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/multi_slot_tone_correlator_top.sv
// Top level of the multi-slot tone correlator.
//
//  channel  dir  handshake        carries
//  i_in     in   valid/ready      cmd, raw_sample, slot, read_mode, frame_end
//  o_out    out  valid/ready      accumulators of one slot and mode, frames_done
//  i_cfg_*  in   write enable     phase_step (index 0), max_frames (index 1)
//
// One request per cycle sustained while the output does not stall; a read result
// passes through the queue entry written at accept, the slot-row read register
// and the readout register. Throughput is set by the single read-modify-write
// port on the slot-row memory, with a one-deep forward path.
// After reset all MAX_SLOTS rows of the slot memory are zeroed, one row a cycle;
// i_in.ready stays low meanwhile. Output stalls back up through the queue.
`default_nettype none
module multi_slot_tone_correlator_top import mstc_pkg::*; #(
    parameter int MAX_SLOTS       = 512,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    mstc_in_if.sink                    i_in,
    mstc_out_if.source                 o_out
);

    t_entry  push_entry, head;
    t_q_stat q_stat;
    logic    push, pop, clearing;

    mstc_front #(.MAX_SLOTS(MAX_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_clearing(clearing), .i_q_stat(q_stat), .in_ch(i_in),
        .o_push(push), .o_entry(push_entry)
    );

    mstc_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_entry(push_entry),
        .i_pop(pop), .o_entry(head), .o_stat(q_stat)
    );

    mstc_back #(.MAX_SLOTS(MAX_SLOTS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q(head), .i_q_stat(q_stat),
        .o_pop(pop), .o_clearing(clearing), .out_ch(o_out)
    );

    // no requests taken while the slot memory is being zeroed
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !i_in.ready) else $error("request accepted during clear");

    // queue never written when full nor read when empty
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full) && !(pop && q_stat.empty))
        else $error("queue overflow or underflow");

    // no readout produced before the memory is cleared
    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_out.valid) else $error("result during clear");

endmodule
`default_nettype wire

// File: hw/rtl/mstc_front.sv
// Front end: config registers, frame/phase tracking, request classification.
`default_nettype none
module mstc_front import mstc_pkg::*; #(
    parameter int MAX_SLOTS = 512
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_clearing,
    input  wire t_q_stat               i_q_stat,
    mstc_in_if.sink                    in_ch,
    output logic                       o_push,
    output t_entry                     o_entry
);

    logic [PHASE_W-1:0] r_phase_step, r_phase_acc;
    logic [CNT_W-1:0]   r_max_frames, r_frame_count;
    logic               accept, live, slot_ok;

    assign in_ch.ready = !i_clearing && !i_q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign live        = r_frame_count < r_max_frames;
    assign slot_ok     = 32'(in_ch.slot) < 32'(MAX_SLOTS);

    always_comb begin
        o_entry.raw    = in_ch.raw_sample;
        o_entry.slot   = in_ch.slot;
        o_entry.mode   = in_ch.read_mode;
        o_entry.phase  = r_phase_acc;
        o_entry.frames = r_frame_count;
        o_push         = 1'b0;
        o_entry.kind   = K_ACC;
        if (in_ch.cmd) begin
            o_push = accept;
            o_entry.kind = (slot_ok && in_ch.read_mode < 3'(NMODES)) ? K_READ : K_READZ;
        end else begin
            o_push = accept && live && slot_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= PHASE_STEP_RST;
            r_max_frames  <= MAX_FRAMES_RST;
            r_phase_acc   <= '0;
            r_frame_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                    CFG_MAX_FRAMES: r_max_frames <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept && !in_ch.cmd && live && in_ch.frame_end) begin
                r_phase_acc   <= r_phase_acc + r_phase_step;
                r_frame_count <= r_frame_count + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mstc_queue.sv
// Short request queue between front and back.
`default_nettype none
module mstc_queue import mstc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_entry i_entry,
    input  wire logic i_pop,
    output t_entry    o_entry,
    output t_q_stat   o_stat
);

    localparam int PW = $clog2(QDEPTH);

    t_entry          r_slots [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_entry      = r_slots[r_rp];
    assign o_stat.empty = r_cnt == '0;
    assign o_stat.full  = r_cnt == (PW+1)'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mstc_back.sv
// Back end: slot memory, products, read-modify-write, readout register.
`default_nettype none
module mstc_back import mstc_pkg::*; #(
    parameter int MAX_SLOTS       = 512,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_entry  i_q,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_clearing,
    mstc_out_if.source   out_ch
);

    localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int TB    = SINE_TABLE_BITS;
    localparam int QB    = TB - 2;
    localparam int TAB_N = 1 << TB;
    localparam int QTR   = TAB_N / 4;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int SERIES_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef logic signed [15:0] t_qtr_tab [QTR];

    // sin(pi/2 * m / QTR) in Q1.15, Taylor series in Q30
    function automatic logic signed [15:0] quarter_sine(input int m);
        logic [63:0]        x, term;
        logic signed [63:0] acc, r;
        x    = (HALF_PI_Q30 * 64'(m)) / QTR;
        term = x;
        acc  = signed'(x);
        for (int n = 0; n < 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[n];
            if (n % 2 == 0) acc = acc - signed'(term);
            else            acc = acc + signed'(term);
        end
        if (acc < 0) acc = 0;
        r = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (r > 32767) r = 32767;
        return 16'(r);
    endfunction

    // first quadrant only; the rest is folded by symmetry
    function automatic t_qtr_tab build_tab();
        t_qtr_tab t;
        for (int m = 0; m < QTR; m++) t[m] = quarter_sine(m);
        return t;
    endfunction

    localparam t_qtr_tab QTR_TAB = build_tab();
    localparam logic signed [15:0] SIN_PEAK = quarter_sine(QTR);

    // full-turn sine from the quarter table
    function automatic logic signed [15:0] tab_sine(input logic [TB-1:0] k);
        logic [QB-1:0]      rem, mir;
        logic signed [15:0] mag;
        rem = k[QB-1:0];
        mir = '0 - rem;
        if (!k[QB])         mag = QTR_TAB[rem];
        else if (rem == '0) mag = SIN_PEAK;
        else                mag = QTR_TAB[mir];
        return k[TB-1] ? -mag : mag;
    endfunction

    typedef struct packed {
        logic signed [RAW_W-1:0]  v;
        logic        [PEAK_W-1:0] sq;
        logic signed [24:0]       ps;
        logic signed [24:0]       pc;
        logic        [PEAK_W-1:0] mag;
    } t_prod;

    t_row            mem [MAX_SLOTS];
    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;
    logic            r_s1_valid, r_out_valid;
    t_entry          r_s1;
    logic [AW-1:0]   r_s1_addr;
    t_row            r_s1_row;
    t_prod [NMODES-1:0] r_prod, prod;
    t_result         r_out, res;
    t_row            new_row;

    logic            out_room, s1_done, s1_free, s1_acc, fwd;
    logic [AW-1:0]   rd_addr;
    logic [TB-1:0]   k_sin, k_cos;

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    assign o_clearing = r_clearing;
    assign out_room   = !r_out_valid || out_ch.ready;
    assign s1_acc     = r_s1.kind == K_ACC;
    assign s1_done    = r_s1_valid && (s1_acc || out_room);
    assign s1_free    = !r_s1_valid || s1_done;
    assign o_pop      = !r_clearing && !i_q_stat.empty && s1_free;
    assign rd_addr    = AW'(i_q.slot);
    assign fwd        = s1_done && s1_acc && (r_s1_addr == rd_addr);

    assign k_sin = i_q.phase[PHASE_W-1 -: TB];
    assign k_cos = k_sin + TB'(QTR);

    // products per mode, registered before accumulation
    always_comb begin
        logic signed [RAW_W-1:0]   v;
        logic signed [2*RAW_W-1:0] vv;
        logic signed [RAW_W+15:0]  ms, mc;
        logic signed [RAW_W:0]     neg;
        for (int m = 0; m < NMODES; m++) begin
            v   = decode(i_q.raw, MODE_W'(m));
            vv  = v * v;
            ms  = v * tab_sine(k_sin);
            mc  = v * tab_sine(k_cos);
            neg = -{v[RAW_W-1], v};
            prod[m].v   = v;
            prod[m].sq  = vv[46:23];
            prod[m].ps  = ms[RAW_W+15:15];
            prod[m].pc  = mc[RAW_W+15:15];
            prod[m].mag = v[RAW_W-1] ? neg[PEAK_W-1:0] : v;
        end
    end

    // accumulate into the slot row
    always_comb begin
        logic [ACC_W:0] sqs;
        new_row       = r_s1_row;
        new_row.count = (r_s1_row.count == '1) ? r_s1_row.count : r_s1_row.count + 1'b1;
        for (int m = 0; m < NMODES; m++) begin
            new_row.cells[m].sum = sat_add(r_s1_row.cells[m].sum,
                                           ACC_W'(r_prod[m].v));
            sqs = {1'b0, r_s1_row.cells[m].square} + (ACC_W+1)'(r_prod[m].sq);
            new_row.cells[m].square = sqs[ACC_W] ? '1 : sqs[ACC_W-1:0];
            new_row.cells[m].sine   = sat_add(r_s1_row.cells[m].sine,
                                              ACC_W'(r_prod[m].ps));
            new_row.cells[m].cosine = sat_add(r_s1_row.cells[m].cosine,
                                              ACC_W'(r_prod[m].pc));
            if (r_prod[m].mag > r_s1_row.cells[m].peak)
                new_row.cells[m].peak = r_prod[m].mag;
        end
    end

    always_comb begin
        t_cell c;
        c   = '0;
        res = '0;
        res.frames_done = r_s1.frames;
        if (r_s1.kind == K_READ && r_s1.mode < MODE_W'(NMODES)) begin
            c = r_s1_row.cells[r_s1.mode];
            res.sample_count = r_s1_row.count;
            res.sum_value    = c.sum;
            res.sum_square   = c.square;
            res.sine_corr    = c.sine;
            res.cosine_corr  = c.cosine;
            res.peak_abs     = c.peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing)
            mem[r_clr_addr] <= '0;
        else if (s1_done && s1_acc)
            mem[r_s1_addr] <= new_row;
        if (o_pop)
            r_s1_row <= fwd ? new_row : mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1      <= i_q;
            r_s1_addr <= rd_addr;
            r_prod    <= prod;
        end
        if (s1_done && !s1_acc)
            r_out <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAX_SLOTS - 1)) r_clearing <= 1'b0;
            end
            if (o_pop)        r_s1_valid <= 1'b1;
            else if (s1_done) r_s1_valid <= 1'b0;
            if (s1_done && !s1_acc) r_out_valid <= 1'b1;
            else if (out_ch.ready)  r_out_valid <= 1'b0;
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.sample_count = r_out.sample_count;
    assign out_ch.sum_value    = r_out.sum_value;
    assign out_ch.sum_square   = r_out.sum_square;
    assign out_ch.sine_corr    = r_out.sine_corr;
    assign out_ch.cosine_corr  = r_out.cosine_corr;
    assign out_ch.peak_abs     = r_out.peak_abs;
    assign out_ch.frames_done  = r_out.frames_done;

endmodule
`default_nettype wire
